// File: design/sensor_packet_deframer_unit_defines.svh
// Assertion macros shared by the deframer modules
`ifndef SENSOR_PACKET_DEFRAMER_UNIT_DEFINES_SVH
`define SENSOR_PACKET_DEFRAMER_UNIT_DEFINES_SVH

// Check a consequence in the same cycle
`define SPD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the following cycle
`define SPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/spd_pkg.sv
// Shared types, constants and helpers of the sensor packet deframer
`default_nettype none
package spd_pkg;

    localparam int MAX_WORDS_DEFAULT = 15;

    localparam logic [7:0] CH_S = 8'h73;
    localparam logic [7:0] CH_N = 8'h6E;
    localparam logic [7:0] CH_P = 8'h70;
    localparam logic [15:0] HDR_SUM = 16'({8'h00, CH_S}) + 16'({8'h00, CH_N})
        + 16'({8'h00, CH_P});

    typedef struct packed {
        logic [7:0] addr;
        logic       has_payload;
        logic       is_batch;
        logic [3:0] words;
        logic       status;
        logic       bank;
    } job_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } release_t;

    function automatic logic [3:0] word_count(input logic [7:0] t, input int max_words);
        logic [3:0] n;
        begin
            n = t[5:2];
            if (!t[7])
                n = 4'd0;
            else if (!t[6])
                n = 4'd1;
            else if (int'(n) > max_words)
                n = 4'(max_words);
            return n;
        end
    endfunction

endpackage
`default_nettype wire

// File: design/spd_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module spd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 30
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]              rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: design/spd_front.sv
// Front end: header hunt, payload capture, checksum and job issue
`default_nettype none
`include "sensor_packet_deframer_unit_defines.svh"
module spd_front #(
    parameter int MAX_WORDS = spd_pkg::MAX_WORDS_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           rx_valid,
    output logic                                rx_stall,
    input  wire logic [7:0]                     rx_byte,
    output logic                                mem_wr_en,
    output logic [$clog2(2*MAX_WORDS)-1:0]      mem_wr_addr,
    output logic [31:0]                         mem_wr_data,
    output logic                                push,
    output spd_pkg::job_t                       push_job,
    input  wire logic                           queue_full,
    input  wire spd_pkg::release_t              bank_release
);

    localparam int ADDR_W = $clog2(2*MAX_WORDS);

    localparam logic [2:0] PH_SEEK_S  = 3'd0;
    localparam logic [2:0] PH_SEEK_N  = 3'd1;
    localparam logic [2:0] PH_SEEK_P  = 3'd2;
    localparam logic [2:0] PH_TYPE    = 3'd3;
    localparam logic [2:0] PH_ADDR    = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_CK_HIGH = 3'd6;
    localparam logic [2:0] PH_CK_LOW  = 3'd7;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  addr_reg, addr_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  ckh_reg, ckh_next;
    logic [23:0] shift_reg, shift_next;
    logic        bank_reg, bank_next;
    logic [1:0]  busy_reg, busy_next;

    logic        accept;
    logic [3:0]  words;
    logic [5:0]  cnt_inc;
    logic        bad_sum;
    logic [ADDR_W-1:0] word_addr;

    assign words    = spd_pkg::word_count(type_reg, MAX_WORDS);
    assign cnt_inc  = cnt_reg + 6'd1;
    assign bad_sum  = ({ckh_reg, rx_byte} != sum_reg);
    assign rx_stall = ((phase_reg == PH_PAYLOAD) && busy_reg[bank_reg])
        || ((phase_reg == PH_CK_LOW) && queue_full);
    assign accept   = rx_valid && !rx_stall;

    assign word_addr = bank_reg ? (ADDR_W'(MAX_WORDS) + ADDR_W'(cnt_reg[5:2]))
                                : ADDR_W'(cnt_reg[5:2]);

    always_comb
    begin
        phase_next  = phase_reg;
        type_next   = type_reg;
        addr_next   = addr_reg;
        cnt_next    = cnt_reg;
        sum_next    = sum_reg;
        ckh_next    = ckh_reg;
        shift_next  = shift_reg;
        bank_next   = bank_reg;
        busy_next   = busy_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = word_addr;
        mem_wr_data = {shift_reg, rx_byte};
        push        = 1'b0;
        push_job.addr        = addr_reg;
        push_job.has_payload = type_reg[7];
        push_job.is_batch    = type_reg[6];
        push_job.words       = bad_sum ? 4'd0 : words;
        push_job.status      = bad_sum;
        push_job.bank        = bank_reg;

        if (bank_release.valid)
        begin
            busy_next[bank_release.bank] = 1'b0;
        end

        if (accept)
        begin
            unique case (phase_reg)
                PH_SEEK_S:
                begin
                    if (rx_byte == spd_pkg::CH_S)
                        phase_next = PH_SEEK_N;
                end
                PH_SEEK_N:
                begin
                    if (rx_byte == spd_pkg::CH_N)
                        phase_next = PH_SEEK_P;
                    else if (rx_byte != spd_pkg::CH_S)
                        phase_next = PH_SEEK_S;
                end
                PH_SEEK_P:
                begin
                    if (rx_byte == spd_pkg::CH_P)
                        phase_next = PH_TYPE;
                    else if (rx_byte == spd_pkg::CH_S)
                        phase_next = PH_SEEK_N;
                    else
                        phase_next = PH_SEEK_S;
                end
                PH_TYPE:
                begin
                    type_next  = rx_byte;
                    sum_next   = spd_pkg::HDR_SUM + {8'h00, rx_byte};
                    phase_next = PH_ADDR;
                end
                PH_ADDR:
                begin
                    addr_next  = rx_byte;
                    sum_next   = sum_reg + {8'h00, rx_byte};
                    cnt_next   = 6'd0;
                    phase_next = (words == 4'd0) ? PH_CK_HIGH : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    shift_next = {shift_reg[15:0], rx_byte};
                    sum_next   = sum_reg + {8'h00, rx_byte};
                    cnt_next   = cnt_inc;
                    mem_wr_en  = (cnt_reg[1:0] == 2'd3);
                    if (cnt_inc >= {words, 2'b00})
                        phase_next = PH_CK_HIGH;
                end
                PH_CK_HIGH:
                begin
                    ckh_next   = rx_byte;
                    phase_next = PH_CK_LOW;
                end
                PH_CK_LOW:
                begin
                    push       = 1'b1;
                    phase_next = PH_SEEK_S;
                    if (!bad_sum && (words != 4'd0))
                    begin
                        busy_next[bank_reg] = 1'b1;
                        bank_next = ~bank_reg;
                    end
                end
                default:
                begin
                    phase_next = PH_SEEK_S;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEEK_S;
            type_reg  <= 8'h00;
            addr_reg  <= 8'h00;
            cnt_reg   <= 6'd0;
            sum_reg   <= 16'h0000;
            ckh_reg   <= 8'h00;
            bank_reg  <= 1'b0;
            busy_reg  <= 2'b00;
        end
        else
        begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            addr_reg  <= addr_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            ckh_reg   <= ckh_next;
            bank_reg  <= bank_next;
            busy_reg  <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    `SPD_ASSERT_NOW(a_no_write_busy_bank, clk, rst_n, mem_wr_en, !busy_reg[bank_reg], "payload write into a bank still being read")

endmodule
`default_nettype wire

// File: design/spd_job_queue.sv
// Two-entry job queue between the front end and the result sequencer
`default_nettype none
`include "sensor_packet_deframer_unit_defines.svh"
module spd_job_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire spd_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output spd_pkg::job_t      head,
    output logic               nonempty
);

    spd_pkg::job_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign nonempty = (count_reg != 2'd0);
    assign head     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    `SPD_ASSERT_NOW(a_push_not_full, clk, rst_n, push, !full, "job pushed into a full queue")
    `SPD_ASSERT_NOW(a_pop_not_empty, clk, rst_n, pop, nonempty, "job popped from an empty queue")

endmodule
`default_nettype wire

// File: design/spd_back.sv
// Back end: walk each job's payload words and present result items
`default_nettype none
`include "sensor_packet_deframer_unit_defines.svh"
module spd_back #(
    parameter int MAX_WORDS = spd_pkg::MAX_WORDS_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       job_ready,
    input  wire spd_pkg::job_t              job,
    output logic                            pop,
    output logic                            mem_rd_en,
    output logic [$clog2(2*MAX_WORDS)-1:0]  mem_rd_addr,
    input  wire logic [31:0]                mem_rd_data,
    output spd_pkg::release_t               bank_release,
    output logic                            result_valid,
    input  wire logic                       result_stall,
    output logic [7:0]                      reg_address,
    output logic [31:0]                     reg_value,
    output logic                            has_payload,
    output logic                            is_batch,
    output logic [3:0]                      word_index,
    output logic                            frame_status,
    output logic                            last_word
);

    localparam int ADDR_W = $clog2(2*MAX_WORDS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]    state_reg, state_next;
    spd_pkg::job_t job_reg, job_next;
    logic [3:0]    k_reg, k_next;
    logic [31:0]   value_reg, value_next;
    logic          last_reg, last_next;

    logic          out_accept;
    logic          rd_bank;
    logic [3:0]    rd_k;

    assign out_accept = (state_reg == ST_HOLD) && !result_stall;

    assign mem_rd_addr = rd_bank ? (ADDR_W'(MAX_WORDS) + ADDR_W'(rd_k)) : ADDR_W'(rd_k);

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        k_next     = k_reg;
        value_next = value_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        mem_rd_en  = 1'b0;
        rd_bank    = job_reg.bank;
        rd_k       = k_reg;
        bank_release.valid = 1'b0;
        bank_release.bank  = job_reg.bank;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_ready)
                begin
                    pop      = 1'b1;
                    job_next = job;
                    k_next   = 4'd0;
                    if (job.words == 4'd0)
                    begin
                        value_next = 32'h0000_0000;
                        last_next  = 1'b1;
                        state_next = ST_HOLD;
                    end
                    else
                    begin
                        mem_rd_en  = 1'b1;
                        rd_bank    = job.bank;
                        rd_k       = 4'd0;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                value_next = mem_rd_data;
                last_next  = (k_reg + 4'd1 == job_reg.words);
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (out_accept)
                begin
                    if (last_reg)
                    begin
                        bank_release.valid = (job_reg.words != 4'd0);
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 4'd1;
                        mem_rd_en  = 1'b1;
                        rd_k       = k_reg + 4'd1;
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        k_reg     <= k_next;
        value_reg <= value_next;
        last_reg  <= last_next;
    end

    assign result_valid = (state_reg == ST_HOLD);
    assign reg_address  = job_reg.addr + {4'h0, k_reg};
    assign reg_value    = value_reg;
    assign has_payload  = job_reg.has_payload;
    assign is_batch     = job_reg.is_batch;
    assign word_index   = k_reg;
    assign frame_status = job_reg.status;
    assign last_word    = last_reg;

    `SPD_ASSERT_NOW(a_error_single, clk, rst_n, result_valid && frame_status, last_word && (word_index == 4'd0) && (reg_value == 32'h0000_0000), "error item is not a single final item")
    `SPD_ASSERT_NEXT(a_release_to_idle, clk, rst_n, bank_release.valid, !result_valid, "bank released while items remain")

endmodule
`default_nettype wire

// File: design/sensor_packet_deframer_unit.sv
// After the checksum low byte is accepted, the job goes through the job queue to the
// back end, which reads each word from the payload RAM and presents it as an item; a
// packet with no words or a bad checksum gives one item. A further word is read only
// once the previous item is taken. Bytes are taken one per cycle; input stalls on the
// checksum low byte while the job queue is full, or on a payload byte while its bank
// still holds undelivered words. Reset clears all control state at once; the payload
// RAM needs no clearing pass. Top level of the sensor packet deframer.
`default_nettype none
module sensor_packet_deframer_unit #(
    parameter int MAX_WORDS = spd_pkg::MAX_WORDS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        rx_valid,
    output logic             rx_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [7:0]       reg_address,
    output logic [31:0]      reg_value,
    output logic             has_payload,
    output logic             is_batch,
    output logic [3:0]       word_index,
    output logic             frame_status,
    output logic             last_word
);

    localparam int DEPTH  = 2 * MAX_WORDS;
    localparam int ADDR_W = $clog2(DEPTH);

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [31:0]       wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [31:0]       rd_data;
    logic              push;
    spd_pkg::job_t     push_job;
    logic              queue_full;
    logic              pop;
    spd_pkg::job_t     head;
    logic              nonempty;
    spd_pkg::release_t bank_release;

    spd_front #(.MAX_WORDS(MAX_WORDS)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_valid     (rx_valid),
        .rx_stall     (rx_stall),
        .rx_byte      (rx_byte),
        .mem_wr_en    (wr_en),
        .mem_wr_addr  (wr_addr),
        .mem_wr_data  (wr_data),
        .push         (push),
        .push_job     (push_job),
        .queue_full   (queue_full),
        .bank_release (bank_release)
    );

    spd_job_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .head     (head),
        .nonempty (nonempty)
    );

    spd_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    spd_back #(.MAX_WORDS(MAX_WORDS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_ready    (nonempty),
        .job          (head),
        .pop          (pop),
        .mem_rd_en    (rd_en),
        .mem_rd_addr  (rd_addr),
        .mem_rd_data  (rd_data),
        .bank_release (bank_release),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .reg_address  (reg_address),
        .reg_value    (reg_value),
        .has_payload  (has_payload),
        .is_batch     (is_batch),
        .word_index   (word_index),
        .frame_status (frame_status),
        .last_word    (last_word)
    );

endmodule
`default_nettype wire
